/* rtl/core/u8u16_pkg.sv */
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam int U8U16_QUEUE_DEPTH = 4;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_LEAD  = 2'd1;
    localparam logic [1:0] ERR_CONT  = 2'd2;
    localparam logic [1:0] ERR_RANGE = 2'd3;

    localparam logic [5:0]  LO_SURR_TAG = 6'b110111;
    localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
    localparam logic [30:0] MAX_CODE    = 31'h10FFFF;

    // one decoded request as it travels from front to back
    typedef struct packed {
        logic [15:0] unit_first;
        logic [2:0]  used;
        logic [1:0]  err;
        logic        pair;
        logic [9:0]  lo_bits;
    } t_entry;

endpackage

/* rtl/core/u8u16_front.sv */
`timescale 1ns / 1ps

module u8u16_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    output logic                 o_push,
    output u8u16_pkg::t_entry    o_entry
);
    import u8u16_pkg::*;

    logic [30:0] r_acc, n_acc;
    logic [2:0]  r_due, n_due;
    logic [2:0]  r_len, n_len;

    logic [30:0] acc_next;
    logic [2:0]  due_dec;
    logic [2:0]  lead_t;
    logic [5:0]  lead_mask;
    logic        lead_ok;
    logic [19:0] offs;

    always_comb begin
        lead_ok   = 1'b1;
        lead_t    = 3'd0;
        lead_mask = 6'h00;
        if (i_byte[7:5] == 3'b110) begin
            lead_t = 3'd1; lead_mask = 6'h1F;
        end else if (i_byte[7:4] == 4'b1110) begin
            lead_t = 3'd2; lead_mask = 6'h0F;
        end else if (i_byte[7:3] == 5'b11110) begin
            lead_t = 3'd3; lead_mask = 6'h07;
        end else if (i_byte[7:2] == 6'b111110) begin
            lead_t = 3'd4; lead_mask = 6'h03;
        end else if (i_byte[7:1] == 7'b1111110) begin
            lead_t = 3'd5; lead_mask = 6'h01;
        end else begin
            lead_ok = 1'b0;
        end
    end

    assign acc_next = {r_acc[24:0], i_byte[5:0]};
    assign due_dec  = r_due - 3'd1;
    assign offs     = acc_next[19:0] - 20'h10000;

    always_comb begin
        n_acc   = r_acc;
        n_due   = r_due;
        n_len   = r_len;
        o_push  = 1'b0;
        o_entry = '0;
        if (i_accept) begin
            if (r_due == 3'd0) begin
                if (!i_byte[7]) begin
                    o_push             = 1'b1;
                    o_entry.unit_first = {8'h00, i_byte};
                    o_entry.used       = 3'd1;
                end else if (lead_ok) begin
                    n_acc = {25'd0, i_byte[5:0] & lead_mask};
                    n_due = lead_t;
                    n_len = lead_t + 3'd1;
                end else begin
                    o_push      = 1'b1;
                    o_entry.err = ERR_LEAD;
                end
            end else if (i_byte[7:6] != 2'b10) begin
                // broken sequence, byte dropped
                n_acc       = '0;
                n_due       = 3'd0;
                n_len       = 3'd0;
                o_push      = 1'b1;
                o_entry.err = ERR_CONT;
            end else begin
                n_acc = acc_next;
                n_due = due_dec;
                if (due_dec == 3'd0) begin
                    n_acc  = '0;
                    n_len  = 3'd0;
                    o_push = 1'b1;
                    if (acc_next[30:16] == 15'd0) begin
                        o_entry.unit_first = acc_next[15:0];
                        o_entry.used       = r_len;
                    end else if (acc_next > MAX_CODE) begin
                        o_entry.err = ERR_RANGE;
                    end else begin
                        o_entry.unit_first = {HI_SURR_TAG, offs[19:10]};
                        o_entry.used       = r_len;
                        o_entry.pair       = 1'b1;
                        o_entry.lo_bits    = offs[9:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_due <= 3'd0;
            r_len <= 3'd0;
        end else begin
            r_acc <= n_acc;
            r_due <= n_due;
            r_len <= n_len;
        end
    end

endmodule

/* rtl/core/u8u16_queue.sv */
`timescale 1ns / 1ps

module u8u16_queue #(
    parameter int DEPTH = u8u16_pkg::U8U16_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  u8u16_pkg::t_entry    i_entry,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output u8u16_pkg::t_entry    o_entry
);
    import u8u16_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry          r_slot [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_entry = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* rtl/core/u8u16_back.sv */
`timescale 1ns / 1ps

module u8u16_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  u8u16_pkg::t_entry    i_entry,
    output logic                 o_pop,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [15:0]          o_code_unit,
    output logic [2:0]           o_bytes_used,
    output logic [1:0]           o_error,
    output logic                 o_last
);
    import u8u16_pkg::*;

    logic        r_valid;
    logic [15:0] r_unit;
    logic [2:0]  r_used;
    logic [1:0]  r_err;
    logic        r_last;
    logic        r_pend;
    logic [9:0]  r_lo_bits;
    logic        slot_free;

    // output slot can take a new result when empty or being drained
    assign slot_free = !r_valid || !i_out_stall;
    assign o_pop     = slot_free && !r_pend && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (slot_free) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= !i_empty;
                r_pend  <= !i_empty && i_entry.pair;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            if (r_pend) begin
                r_unit <= {LO_SURR_TAG, r_lo_bits};
                r_used <= 3'd0;
                r_err  <= ERR_NONE;
                r_last <= 1'b1;
            end else begin
                r_unit    <= i_entry.unit_first;
                r_used    <= i_entry.used;
                r_err     <= i_entry.err;
                r_last    <= !i_entry.pair;
                r_lo_bits <= i_entry.lo_bits;
            end
        end
    end

    assign o_out_valid  = r_valid;
    assign o_code_unit  = r_unit;
    assign o_bytes_used = r_used;
    assign o_error      = r_err;
    assign o_last       = r_last;

endmodule

/* rtl/core/utf8_to_utf16_decoder.sv */
`timescale 1ns / 1ps
// channel | direction | handshake              | payload
// in      | input     | i_in_valid / o_in_stall  | i_in_byte[7:0]
// out     | output    | o_out_valid / i_out_stall| o_code_unit, o_bytes_used, o_error, o_last
//
// one byte accepted per cycle while the decode queue has room; path: queue, output register
// a surrogate pair holds the output register for its high and low units, but a pair
// needs at least four input bytes, so the output keeps pace at one byte per cycle and
// the queue fills only while i_out_stall is held
// synchronous active-low reset clears the sequence state, the queue and the output
// o_in_stall rises only when the queue is full; results wait in the output register

module utf8_to_utf16_decoder #(
    parameter int QUEUE_DEPTH = u8u16_pkg::U8U16_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_code_unit,
    output logic [2:0]  o_bytes_used,
    output logic [1:0]  o_error,
    output logic        o_last
);
    import u8u16_pkg::*;

    t_entry push_entry, head_entry;
    logic   push, pop, q_full, q_empty, accept;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    u8u16_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in_byte),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_entry (head_entry)
    );

    u8u16_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_entry      (head_entry),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_code_unit  (o_code_unit),
        .o_bytes_used (o_bytes_used),
        .o_error      (o_error),
        .o_last       (o_last)
    );

endmodule
